@@ rtl/assert_macros.svh @@
// Assertion helpers. Both take a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ rtl/sss_pkg.sv @@
package sss_pkg;

  localparam int DefDepth     = 64;
  localparam int DefNameBytes = 20;

  // input tdata layout
  localparam int InKeyW  = 160;
  localparam int InDataW = 200;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_MODIFY = 2'd1,
    CMD_GET    = 2'd2,
    CMD_POP    = 2'd3
  } sss_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } sss_status_e;

  typedef struct packed {
    logic entry_we;  // key and level write
    logic value_we;  // value write
    logic rd_en;
  } sss_mem_ctl_t;

endpackage

@@ rtl/sss_mem.sv @@
module sss_mem #(
  parameter int DEPTH   = sss_pkg::DefDepth,
  parameter int ENTRY_W = 8 * sss_pkg::DefNameBytes + 8
) (
  input  logic                       clk_i,
  input  sss_pkg::sss_mem_ctl_t      ctl_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [ENTRY_W-1:0]         wr_entry_i,
  input  logic [31:0]                wr_value_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [ENTRY_W-1:0]         rd_entry_o,
  output logic [31:0]                rd_value_o
);

  // {level, key} and value live apart so modify can rewrite the value alone
  logic [ENTRY_W-1:0] entry_mem [DEPTH];
  logic [31:0]        value_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.entry_we) begin
      entry_mem[wr_addr_i] <= wr_entry_i;
    end
    if (ctl_i.value_we) begin
      value_mem[wr_addr_i] <= wr_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_entry_o <= entry_mem[rd_addr_i];
      rd_value_o <= value_mem[rd_addr_i];
    end
  end

endmodule

@@ rtl/scoped_symbol_stack.sv @@
// Push writes its entry in START; modify/get read entries from the top down until a key hit
// or the bottom; pop removes entries from the top while their level matches. One request
// in flight at a time: the next is taken the cycle after the result is registered.
// Reset clears the entry count and handshake state; memory contents are not
// cleared, since only entries below the count are ever read.
`include "assert_macros.svh"

module scoped_symbol_stack #(
  parameter int DEPTH      = sss_pkg::DefDepth,
  parameter int NAME_BYTES = sss_pkg::DefNameBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // cmd
  input  logic [1:0]                    s_axis_tuser_i,
  // key_low, key_mid, key_high, data_bits, scope
  input  logic [sss_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status
  output logic [1:0]                    m_axis_tuser_o,
  // read_bits, entries_used, zero pad
  output logic [((32 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int KeyW   = 8 * NAME_BYTES;
  localparam int EntryW = KeyW + 8;
  localparam int AW     = $clog2(DEPTH);
  localparam int CntW   = $clog2(DEPTH + 1);
  localparam int OutW   = ((32 + CntW + 7) / 8) * 8;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]                  state_q;
  sss_pkg::sss_cmd_e           cmd_q;
  logic [KeyW-1:0]             key_q;
  logic [31:0]                 data_q;
  logic [7:0]                  scope_q;
  logic [CntW-1:0]             cnt_q;
  logic [CntW-1:0]             ptr_q;
  logic [AW-1:0]               raddr_q;
  logic                        rdv_q;
  sss_pkg::sss_status_e        res_status_q;
  logic [31:0]                 res_rd_q;
  logic                        out_valid_q;
  sss_pkg::sss_status_e        out_status_q;
  logic [31:0]                 out_rd_q;
  logic [CntW-1:0]             out_cnt_q;

  logic [sss_pkg::InKeyW-1:0]  key_raw;
  logic [KeyW-1:0]             key_n;
  logic                        accept;
  logic                        full;
  logic                        issue;
  logic                        key_hit;
  logic                        lvl_hit;
  logic                        done;
  logic                        slot_free;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               wr_addr;
  logic [EntryW-1:0]           rd_entry;
  logic [31:0]                 rd_value;
  sss_pkg::sss_mem_ctl_t       mem_ctl;

  assign key_raw         = s_axis_tdata_i[sss_pkg::InKeyW-1:0];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // name ends at its first zero byte; bytes past it read as zero
  always_comb begin
    logic ended;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (key_raw[8*b +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      key_n[8*b +: 8] = ended ? 8'd0 : key_raw[8*b +: 8];
    end
  end

  assign full      = (cnt_q == CntW'(DEPTH));
  assign issue     = (state_q == S_SCAN) && (ptr_q != '0);
  assign rd_addr   = AW'(ptr_q - CntW'(1));
  assign key_hit   = (rd_entry[KeyW-1:0] == key_q);
  assign lvl_hit   = ({1'b0, rd_entry[EntryW-1:KeyW]} == ({1'b0, scope_q} + 9'd1));
  assign slot_free = !out_valid_q || m_axis_tready_i;

  // pop walks down while levels match; lookups stop at the first hit
  always_comb begin
    if (rdv_q) begin
      done = (cmd_q == sss_pkg::CMD_POP) ? !lvl_hit : key_hit;
    end else begin
      done = (ptr_q == '0);
    end
  end

  // memory writes only happen in START and SCAN; scan reads may overlap them
  assign mem_ctl.entry_we = (state_q == S_START) && (cmd_q == sss_pkg::CMD_PUSH) && !full;
  assign mem_ctl.value_we = mem_ctl.entry_we ||
                            ((state_q == S_SCAN) && rdv_q && key_hit &&
                             (cmd_q == sss_pkg::CMD_MODIFY));
  assign mem_ctl.rd_en    = issue;
  assign wr_addr          = (state_q == S_START) ? AW'(cnt_q) : raddr_q;

  sss_mem #(
    .DEPTH   (DEPTH),
    .ENTRY_W (EntryW)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .wr_addr_i  (wr_addr),
    .wr_entry_i ({scope_q, key_q}),
    .wr_value_i (data_q),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry),
    .rd_value_o (rd_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rdv_q <= (state_q == S_SCAN) && !done && issue;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          if (cmd_q == sss_pkg::CMD_PUSH) begin
            if (!full) begin
              cnt_q <= cnt_q + CntW'(1);
            end
            state_q <= S_RESP;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rdv_q && (cmd_q == sss_pkg::CMD_POP) && lvl_hit) begin
            cnt_q <= CntW'(raddr_q);
          end
          if (done) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if ((state_q == S_RESP) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q   <= sss_pkg::sss_cmd_e'(s_axis_tuser_i);
          key_q   <= key_n;
          data_q  <= s_axis_tdata_i[191:160];
          scope_q <= s_axis_tdata_i[199:192];
        end
      end
      S_START: begin
        ptr_q <= cnt_q;
        if (full) begin
          res_status_q <= sss_pkg::ST_FULL;
          res_rd_q     <= '0;
        end else begin
          res_status_q <= sss_pkg::ST_OK;
          res_rd_q     <= data_q;
        end
      end
      S_SCAN: begin
        if (issue) begin
          ptr_q   <= ptr_q - CntW'(1);
          raddr_q <= rd_addr;
        end
        if (done) begin
          if (cmd_q == sss_pkg::CMD_POP) begin
            res_status_q <= sss_pkg::ST_OK;
            res_rd_q     <= '0;
          end else if (rdv_q && key_hit) begin
            res_status_q <= sss_pkg::ST_OK;
            res_rd_q     <= (cmd_q == sss_pkg::CMD_GET) ? rd_value : data_q;
          end else begin
            res_status_q <= sss_pkg::ST_NOT_FOUND;
            res_rd_q     <= '0;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_status_q <= res_status_q;
          out_rd_q     <= res_rd_q;
          out_cnt_q    <= cnt_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutW'({out_cnt_q, out_rd_q});

  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntW'(DEPTH), "entry count above depth")
  `ASSERT_AT(a_wr_state, clk_i, rst_ni, (mem_ctl.entry_we || mem_ctl.value_we) |-> (state_q == S_START || state_q == S_SCAN), "memory write outside command execution")
  `ASSERT_AT(a_cnt_step, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + 1'b1 && $past(cmd_q) == sss_pkg::CMD_PUSH) || (cnt_q < $past(cnt_q) && $past(cmd_q) == sss_pkg::CMD_POP)), "entry count moved without push or pop")
  `ASSERT_AT(a_rdv_scan, clk_i, rst_ni, rdv_q |-> (state_q == S_SCAN), "read data pending outside scan")

endmodule
